@@ sv/wgft_pkg.sv @@
package wgft_pkg;

   // Field widths
   localparam int TAP_W   = 16;
   localparam int COEF_W  = 24;
   localparam int ADDR_W  = 26;
   localparam int CFG_W   = 11;

   // Filter geometry
   localparam int TAPS    = 9;
   localparam int TAP_IW  = $clog2(TAPS);
   localparam int ROWS    = 6;
   localparam int COLS    = 3;
   localparam int RC_W    = 3;

   // Internal arithmetic widths
   localparam int TMP_W   = 21;  // one pass of 24G over a tap column
   localparam int SUM_W   = 26;  // full 24G * g * 24G^T sum
   localparam int Y_W     = 27;  // 4*|S| + 4
   localparam int Q_W     = 25;  // quotient before clamping
   localparam int P_W     = 54;  // reciprocal product

   // floor(y / 9) via reciprocal: q0 = (y * floor(2^30/9)) >> 30, then one fix-up
   localparam int               RECIP_SHIFT = 30;
   localparam logic [Y_W-1:0]   RECIP_MUL   = Y_W'(119304647);
   localparam logic [Y_W-1:0]   DIVISOR     = Y_W'(9);
   localparam logic [Q_W-1:0]   POS_LIMIT   = Q_W'(8388607);
   localparam logic [Q_W-1:0]   NEG_LIMIT   = Q_W'(8388608);

   localparam int               WGFT_MAX_CHANNELS = 1024;
   localparam logic [CFG_W-1:0] CFG_RESET         = CFG_W'(256);

   // Register indexes of the write port
   typedef enum logic [0:0] {
      CSR_OUT_CHANNELS = 1'b0,
      CSR_IN_CHANNELS  = 1'b1
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic              store_tap;
      logic [TAP_IW-1:0] tap_index;
      logic              prep;
      logic              issue;
      logic [RC_W-1:0]   row_i;
      logic [RC_W-1:0]   col_j;
      logic              last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic advance;
   } status_type;

   // One row of 24G applied to three values: rows are
   // (6,0,0) (-4,-4,-4) (-4,4,-4) (1,2,4) (1,-2,4) (0,0,24)
   function automatic logic signed [SUM_W-1:0] wgft_row(
      input logic [RC_W-1:0]         idx,
      input logic signed [SUM_W-1:0] a0,
      input logic signed [SUM_W-1:0] a1,
      input logic signed [SUM_W-1:0] a2
   );
      logic signed [SUM_W-1:0] r;
      case (idx)
         3'd0: r = (a0 <<< 2) + (a0 <<< 1);
         3'd1: r = -((a0 + a1 + a2) <<< 2);
         3'd2: r = -((a0 - a1 + a2) <<< 2);
         3'd3: r = a0 + (a1 <<< 1) + (a2 <<< 2);
         3'd4: r = a0 - (a1 <<< 1) + (a2 <<< 2);
         3'd5: r = (a2 <<< 4) + (a2 <<< 3);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/wgft_ctrl.sv @@
module wgft_ctrl
   import wgft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_PREP    = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [TAP_IW-1:0] tap_count_ff, tap_count_in;
   logic [RC_W-1:0]   row_ff, row_in;
   logic [RC_W-1:0]   col_ff, col_in;
   logic              take_ok;
   logic              accept;
   logic              issue;
   logic              final_coef;

   localparam logic [TAP_IW-1:0] LAST_TAP = TAP_IW'(TAPS - 1);
   localparam logic [RC_W-1:0]   LAST_RC  = RC_W'(ROWS - 1);

   // Taps are taken while collecting, and during emission up to the eighth
   always_comb begin
      case (state_ff)
         ST_COLLECT: take_ok = 1'b1;
         ST_EMIT:    take_ok = (tap_count_ff != LAST_TAP);
         default:    take_ok = 1'b0;
      endcase
   end

   assign req_stall  = !take_ok;
   assign accept     = req_valid && take_ok;
   assign issue      = (state_ff == ST_EMIT) && status.advance;
   assign final_coef = (row_ff == LAST_RC) && (col_ff == LAST_RC);

   // Next state, tap counter and coefficient walk
   always_comb begin
      state_in     = state_ff;
      tap_count_in = tap_count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (accept) begin
         tap_count_in = (tap_count_ff == LAST_TAP) ? '0 : tap_count_ff + 1'b1;
      end
      case (state_ff)
         ST_COLLECT: begin
            if (accept && (tap_count_ff == LAST_TAP)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
            row_in   = '0;
            col_in   = '0;
         end
         ST_EMIT: begin
            if (issue) begin
               if (col_ff == LAST_RC) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (final_coef) begin
                  state_in = ST_COLLECT;
                  row_in   = '0;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         tap_count_ff <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   // Commands
   always_comb begin
      cmd.store_tap = accept;
      cmd.tap_index = tap_count_ff;
      cmd.prep      = (state_ff == ST_PREP);
      cmd.issue     = issue;
      cmd.row_i     = row_ff;
      cmd.col_j     = col_ff;
      cmd.last      = final_coef;
   end

endmodule

@@ sv/wgft_datapath.sv @@
module wgft_datapath
   import wgft_pkg::*;
#(
   parameter int MAX_CHANNELS = WGFT_MAX_CHANNELS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [TAP_W-1:0]  req_tap_value,
   input  logic                     csr_write_enable,
   input  logic [0:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COEF_W-1:0] rsp_coef_value,
   output logic [ADDR_W-1:0]        rsp_coef_address,
   output logic                     rsp_last,
   input  cmd_type                  cmd,
   output status_type               status
);

   localparam int CW = $clog2(MAX_CHANNELS + 1);
   localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int EW = (CW > CFG_W) ? CW : CFG_W;
   localparam int XW = ((IW + 1) > CW) ? (IW + 1) : CW;
   localparam int MW = IW + CW;
   localparam logic [EW-1:0] MAX_EXT = EW'(MAX_CHANNELS);

   // Configuration registers
   logic [CFG_W-1:0] out_channels_ff;
   logic [CFG_W-1:0] in_channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_channels_ff <= CFG_RESET;
         in_channels_ff  <= CFG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_OUT_CHANNELS: out_channels_ff <= csr_write_data;
            CSR_IN_CHANNELS:  in_channels_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective channel counts: zero counts as one, clamp at the maximum
   function automatic logic [CW-1:0] eff_count(input logic [CFG_W-1:0] r);
      logic [EW-1:0] e;
      logic [CW-1:0] c;
      e = EW'(r);
      if (e == '0) begin
         c = CW'(1);
      end else if (e > MAX_EXT) begin
         c = CW'(MAX_CHANNELS);
      end else begin
         c = CW'(e);
      end
      return c;
   endfunction

   logic [CW-1:0] kk, cc;
   assign kk = eff_count(out_channels_ff);
   assign cc = eff_count(in_channels_ff);

   // Tap store
   logic signed [TAP_W-1:0] tap_store_ff [TAPS];

   always_ff @(posedge clock) begin
      if (cmd.store_tap) begin
         tap_store_ff[cmd.tap_index] <= req_tap_value;
      end
   end

   // First pass of 24G down each tap column
   logic signed [TMP_W-1:0] tmp_ff [ROWS][COLS];
   logic signed [TMP_W-1:0] tmp_in [ROWS][COLS];

   always_comb begin
      for (int i = 0; i < ROWS; i++) begin
         for (int c = 0; c < COLS; c++) begin
            tmp_in[i][c] = TMP_W'(wgft_row(RC_W'(i),
                                           SUM_W'(tap_store_ff[c]),
                                           SUM_W'(tap_store_ff[COLS + c]),
                                           SUM_W'(tap_store_ff[2 * COLS + c])));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         tmp_ff <= tmp_in;
      end
   end

   // Channel counters and address set-up
   logic [IW-1:0]     in_index_ff, out_index_ff;
   logic [XW-1:0]     in_step, out_step;
   logic [2*CW-1:0]   ck_full;
   logic [MW-1:0]     base_mul;
   logic [ADDR_W-1:0] ck_ff;
   logic [ADDR_W-1:0] addr_ff;

   assign in_step  = XW'(in_index_ff) + XW'(1);
   assign out_step = XW'(out_index_ff) + XW'(1);
   assign ck_full  = (2*CW)'(cc) * (2*CW)'(kk);
   assign base_mul = MW'(in_index_ff) * MW'(kk);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_index_ff  <= '0;
         out_index_ff <= '0;
      end else if (cmd.prep) begin
         if (in_step >= XW'(cc)) begin
            in_index_ff <= '0;
            if (out_step >= XW'(kk)) begin
               out_index_ff <= '0;
            end else begin
               out_index_ff <= IW'(out_step);
            end
         end else begin
            in_index_ff <= IW'(in_step);
         end
      end
   end

   // Running address: base on set-up, one C*K stride per coefficient
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         ck_ff   <= ADDR_W'(ck_full);
         addr_ff <= ADDR_W'(base_mul) + ADDR_W'(out_index_ff);
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + ck_ff;
      end
   end

   // Whole pipeline moves when the output register is free
   logic advance;
   logic rsp_valid_ff;
   assign advance        = !rsp_valid_ff || !rsp_stall;
   assign status.advance = advance;

   // Stage 1: second pass of 24G across the selected row
   logic                    s1_valid_ff;
   logic signed [SUM_W-1:0] s1_sum_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic                    s1_last_ff;
   logic signed [SUM_W-1:0] s1_sum_in;

   assign s1_sum_in = wgft_row(cmd.col_j,
                               SUM_W'(tmp_ff[cmd.row_i][0]),
                               SUM_W'(tmp_ff[cmd.row_i][1]),
                               SUM_W'(tmp_ff[cmd.row_i][2]));

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_ff  <= s1_sum_in;
         s1_addr_ff <= addr_ff;
         s1_last_ff <= cmd.last;
      end
   end

   // Stage 2: y = 4*|S| + 4, reciprocal multiply for y / 9
   logic                  s2_valid_ff;
   logic [Y_W-1:0]        s2_y_ff;
   logic [Q_W-1:0]        s2_q0_ff;
   logic                  s2_neg_ff;
   logic [ADDR_W-1:0]     s2_addr_ff;
   logic                  s2_last_ff;
   logic [SUM_W-1:0]      s1_mag;
   logic [Y_W-1:0]        s2_y_in;
   logic [P_W-1:0]        s2_prod;

   assign s1_mag  = s1_sum_ff[SUM_W-1] ? SUM_W'(-s1_sum_ff) : SUM_W'(s1_sum_ff);
   assign s2_y_in = (Y_W'(s1_mag) << 2) + Y_W'(4);
   assign s2_prod = P_W'(s2_y_in) * P_W'(RECIP_MUL);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_y_ff    <= s2_y_in;
         s2_q0_ff   <= Q_W'(s2_prod >> RECIP_SHIFT);
         s2_neg_ff  <= s1_sum_ff[SUM_W-1];
         s2_addr_ff <= s1_addr_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: quotient fix-up, sign and clamp into the output register
   logic [Y_W-1:0]           s3_rem;
   logic [Q_W-1:0]           s3_q;
   logic signed [COEF_W-1:0] s3_value;
   logic signed [COEF_W-1:0] rsp_coef_value_ff;
   logic [ADDR_W-1:0]        rsp_coef_address_ff;
   logic                     rsp_last_ff;

   assign s3_rem = s2_y_ff - ((Y_W'(s2_q0_ff) << 3) + Y_W'(s2_q0_ff));
   assign s3_q   = (s3_rem >= DIVISOR) ? s2_q0_ff + 1'b1 : s2_q0_ff;

   always_comb begin
      if (s2_neg_ff) begin
         s3_value = (s3_q > NEG_LIMIT) ? COEF_W'(-NEG_LIMIT) : COEF_W'(-s3_q);
      end else begin
         s3_value = (s3_q > POS_LIMIT) ? COEF_W'(POS_LIMIT) : COEF_W'(s3_q);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_coef_value_ff   <= s3_value;
         rsp_coef_address_ff <= s2_addr_ff;
         rsp_last_ff         <= s2_last_ff;
      end
   end

   // Valid bits of the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coef_value   = rsp_coef_value_ff;
   assign rsp_coef_address = rsp_coef_address_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ sv/winograd_filter_transform_f4x3.sv @@
// Channel  Direction  Ports
// req      in         req_valid, req_stall, req_tap_value
// rsp      out        rsp_valid, rsp_stall, rsp_coef_value, rsp_coef_address, rsp_last
// csr      in         csr_write_enable, csr_index, csr_write_data
//
// A filter is nine taps. The ninth is followed by a set-up state, then
// 36 coefficients through a three-stage pipeline, one coefficient a cycle
// while rsp is not stalled; the single coefficient output limits the
// throughput. Taps one to eight of the next filter are taken during
// emission. rsp_stall, while rsp_valid is high, freezes the whole
// pipeline. Reset is synchronous and returns the counts to 256 and the
// channel and tap counters to zero.
module winograd_filter_transform_f4x3
   import wgft_pkg::*;
#(
   parameter int MAX_CHANNELS = WGFT_MAX_CHANNELS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [TAP_W-1:0]  req_tap_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COEF_W-1:0] rsp_coef_value,
   output logic [ADDR_W-1:0]        rsp_coef_address,
   output logic                     rsp_last,
   input  logic                     csr_write_enable,
   input  logic [0:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_write_data
);

   cmd_type    cmd;
   status_type status;

   wgft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wgft_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_tap_value    (req_tap_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_coef_value   (rsp_coef_value),
      .rsp_coef_address (rsp_coef_address),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
